// File: rtl/dttn_pkg.sv
package dttn_pkg;

  localparam int unsigned MW = 50;
  localparam int unsigned EW = 12;

  localparam logic [31:0] FLT_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FLT_TEN   = 32'h4120_0000;
  localparam logic [31:0] FLT_TENTH = 32'h3DCC_CCCD;
  localparam logic [31:0] FLT_INF   = 32'h7F80_0000;
  localparam logic [31:0] FLT_QNAN  = 32'h7FC0_0000;
  localparam logic signed [35:0] EXP_MAX = 36'sh0_7FFF_FFFF;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    FP_MUL,
    FP_ADD,
    FP_DIV10
  } fp_op_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_NORM
  } fpu_state_e;

  typedef enum logic [2:0] {
    OPS_ACC_TEN,
    OPS_ACC_DIG,
    OPS_W_DIV,
    OPS_DIG_W,
    OPS_ACC_TMP,
    OPS_BASE_SQ,
    OPS_ACC_BASE
  } opsel_e;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_INT,
    PH_FRAC,
    PH_EXP_FIRST,
    PH_EXP,
    PH_DONE,
    PH_IFOLD
  } phase_e;

  typedef enum logic [4:0] {
    C_IDLE,
    C_INT_MUL,
    C_INT_MUL_W,
    C_INT_ADD,
    C_INT_ADD_W,
    C_FRAC_DIV,
    C_FRAC_DIV_W,
    C_FRAC_MUL,
    C_FRAC_MUL_W,
    C_FRAC_ADD,
    C_FRAC_ADD_W,
    C_FIN,
    C_EXP_INIT,
    C_EXP_STEP,
    C_EXP_STEP_W,
    C_EXP_LAST_W,
    C_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic   init;
    logic   char_load;
    logic   int_fold;
    logic   exp_fold;
    logic   fp_start;
    opsel_e sel;
    logic   exp_init;
    logic   mcnt_step;
    logic   out_load;
    logic   kind;
    logic   man_neg;
    logic   exp_neg;
  } cmd_t;

  typedef struct packed {
    logic fp_done;
    logic exp_zero;
    logic mcnt_one;
    logic mcnt_even;
    logic out_free;
  } status_t;

  function automatic logic [31:0] digit_to_float(input logic [3:0] d);
    logic [31:0] f;
    case (d)
      4'd1: f = 32'h3F80_0000;
      4'd2: f = 32'h4000_0000;
      4'd3: f = 32'h4040_0000;
      4'd4: f = 32'h4080_0000;
      4'd5: f = 32'h40A0_0000;
      4'd6: f = 32'h40C0_0000;
      4'd7: f = 32'h40E0_0000;
      4'd8: f = 32'h4100_0000;
      4'd9: f = 32'h4110_0000;
      default: f = 32'h0000_0000;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/dttn_fpu.sv
module dttn_fpu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  dttn_pkg::fp_op_e    op_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  output logic                done_o,
  output logic [31:0]         res_o
);

  localparam int unsigned MW = dttn_pkg::MW;
  localparam int unsigned EW = dttn_pkg::EW;

  logic [7:0]  a_ex, b_ex, a_e, b_e;
  logic [22:0] a_fr, b_fr;
  logic [23:0] a_man, b_man;
  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [47:0] prod;
  logic signed [EW-1:0] e_mul, e_add;
  logic        mul_nan, mul_inf, add_nan, add_inf;

  logic        a_ge;
  logic [7:0]  big_e, small_e, dshift;
  logic [23:0] big_man, small_man;
  logic [47:0] small_ext, shifted, lost_mask;
  logic        add_sticky;
  logic [48:0] sum;

  logic [23:0] dv, dq10, drem;
  logic [55:0] dprod;
  logic [20:0] dq;
  logic [25:0] dfrac;

  logic [23:0] top;
  logic        guard, stk, up;
  logic signed [EW-1:0] em1;
  logic [31:0] rsum;

  dttn_pkg::fpu_state_e st_d, st_q;
  logic [MW-1:0]        m_d, m_q;
  logic signed [EW-1:0] e_d, e_q;
  logic                 s_d, s_q;
  logic                 spec_d, spec_q;
  logic [31:0]          specv_d, specv_q;
  logic [31:0]          res_d, res_q;
  logic                 done_d, done_q;

  // floor(r * 2^26 / 10) for a remainder r of a divide by ten
  function automatic logic [25:0] frac_tenth(input logic [3:0] r);
    logic [25:0] f;
    case (r)
      4'd1: f = 26'd6710886;
      4'd2: f = 26'd13421772;
      4'd3: f = 26'd20132659;
      4'd4: f = 26'd26843545;
      4'd5: f = 26'd33554432;
      4'd6: f = 26'd40265318;
      4'd7: f = 26'd46976204;
      4'd8: f = 26'd53687091;
      4'd9: f = 26'd60397977;
      default: f = 26'd0;
    endcase
    return f;
  endfunction

  assign a_ex   = a_i[30:23];
  assign b_ex   = b_i[30:23];
  assign a_fr   = a_i[22:0];
  assign b_fr   = b_i[22:0];
  assign a_man  = {a_ex != 8'd0, a_fr};
  assign b_man  = {b_ex != 8'd0, b_fr};
  assign a_e    = (a_ex == 8'd0) ? 8'd1 : a_ex;
  assign b_e    = (b_ex == 8'd0) ? 8'd1 : b_ex;
  assign a_zero = (a_ex == 8'd0) && (a_fr == 23'd0);
  assign b_zero = (b_ex == 8'd0) && (b_fr == 23'd0);
  assign a_inf  = (a_ex == 8'hFF) && (a_fr == 23'd0);
  assign b_inf  = (b_ex == 8'hFF) && (b_fr == 23'd0);
  assign a_nan  = (a_ex == 8'hFF) && (a_fr != 23'd0);
  assign b_nan  = (b_ex == 8'hFF) && (b_fr != 23'd0);

  assign prod    = {24'd0, a_man} * {24'd0, b_man};
  assign e_mul   = $signed({4'd0, a_e}) + $signed({4'd0, b_e}) - 12'sd126;
  assign mul_nan = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
  assign mul_inf = a_inf || b_inf;

  // operands are never negative, so the adder only aligns and adds
  assign a_ge      = a_e >= b_e;
  assign big_e     = a_ge ? a_e : b_e;
  assign small_e   = a_ge ? b_e : a_e;
  assign big_man   = a_ge ? a_man : b_man;
  assign small_man = a_ge ? b_man : a_man;
  assign dshift    = big_e - small_e;
  assign small_ext = {small_man, 24'd0};
  assign lost_mask = ~({48{1'b1}} << dshift);
  assign shifted   = (dshift >= 8'd48) ? 48'd0 : (small_ext >> dshift);
  assign add_sticky = (dshift >= 8'd48) ? (small_man != 24'd0)
                                        : ((small_ext & lost_mask) != 48'd0);
  assign sum     = {1'b0, big_man, 24'd0} + {1'b0, shifted};
  assign e_add   = $signed({4'd0, big_e}) + 12'sd2;
  assign add_nan = a_nan || b_nan;
  assign add_inf = a_inf || b_inf;

  // divide by ten through a reciprocal multiply
  assign dv    = m_q[MW-1:MW-24];
  assign dprod = dv * 32'hCCCC_CCCD;
  assign dq    = dprod[55:35];
  assign dq10  = ({3'd0, dq} << 3) + ({3'd0, dq} << 1);
  assign drem  = dv - dq10;
  assign dfrac = frac_tenth(drem[3:0]);

  assign top   = m_q[MW-1:MW-24];
  assign guard = m_q[MW-25];
  assign stk   = (m_q[MW-26:0] != '0) || s_q;
  assign up    = guard && (stk || top[0]);
  assign em1   = e_q - 12'sd1;
  assign rsum  = {1'b0, em1[7:0], 23'd0} + {8'd0, top} + {31'd0, up};

  always_comb begin
    st_d    = st_q;
    m_d     = m_q;
    e_d     = e_q;
    s_d     = s_q;
    spec_d  = spec_q;
    specv_d = specv_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (st_q)
      dttn_pkg::FS_IDLE: begin
        if (start_i) begin
          s_d    = 1'b0;
          spec_d = 1'b0;
          st_d   = dttn_pkg::FS_NORM;
          case (op_i)
            dttn_pkg::FP_MUL: begin
              m_d     = {prod, 2'b00};
              e_d     = e_mul;
              spec_d  = mul_nan || mul_inf;
              specv_d = mul_nan ? dttn_pkg::FLT_QNAN : dttn_pkg::FLT_INF;
            end
            dttn_pkg::FP_ADD: begin
              m_d     = {1'b0, sum};
              e_d     = e_add;
              s_d     = add_sticky;
              spec_d  = add_nan || add_inf;
              specv_d = add_nan ? dttn_pkg::FLT_QNAN : dttn_pkg::FLT_INF;
            end
            dttn_pkg::FP_DIV10: begin
              m_d  = {a_man, 26'd0};
              e_d  = $signed({4'd0, a_e});
              st_d = dttn_pkg::FS_DIV;
            end
            default: st_d = dttn_pkg::FS_IDLE;
          endcase
        end
      end
      dttn_pkg::FS_DIV: begin
        m_d  = {3'd0, dq, dfrac};
        s_d  = (drem[3:0] != 4'd0) && (drem[3:0] != 4'd5);
        st_d = dttn_pkg::FS_NORM;
      end
      dttn_pkg::FS_NORM: begin
        if (spec_q) begin
          res_d  = specv_q;
          done_d = 1'b1;
          st_d   = dttn_pkg::FS_IDLE;
        end else if (m_q == '0) begin
          res_d  = 32'd0;
          done_d = 1'b1;
          st_d   = dttn_pkg::FS_IDLE;
        end else if (e_q < 12'sd1) begin
          m_d = {1'b0, m_q[MW-1:1]};
          s_d = s_q || m_q[0];
          e_d = e_q + 12'sd1;
        end else if (!m_q[MW-1] && (e_q > 12'sd1)) begin
          m_d = {m_q[MW-2:0], 1'b0};
          e_d = e_q - 12'sd1;
        end else begin
          if (e_q >= 12'sd255) begin
            res_d = dttn_pkg::FLT_INF;
          end else if (rsum >= dttn_pkg::FLT_INF) begin
            res_d = dttn_pkg::FLT_INF;
          end else begin
            res_d = rsum;
          end
          done_d = 1'b1;
          st_d   = dttn_pkg::FS_IDLE;
        end
      end
      default: st_d = dttn_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= dttn_pkg::FS_IDLE;
      done_q <= 1'b0;
      spec_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      spec_q <= spec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    e_q     <= e_d;
    s_q     <= s_d;
    specv_q <= specv_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/dttn_datapath.sv
module dttn_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         char_i,
  input  dttn_pkg::cmd_t     cmd_i,
  output dttn_pkg::status_t  status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [31:0]        out_value_o,
  output logic               out_kind_o
);

  logic [31:0] acc_d, acc_q, w_d, w_q, tmp_d, tmp_q, base_d, base_q;
  logic signed [31:0] expv_d, expv_q;
  logic [30:0] mcnt_d, mcnt_q;
  logic [7:0]  char_d, char_q;
  dttn_pkg::opsel_e sel_d, sel_q;
  logic        outv_d, outv_q, outk_d, outk_q;
  logic [31:0] outd_d, outd_q;

  logic [31:0] digit_f, fp_a, fp_b, fp_res, ifold, emag, fin_f, fin_i;
  dttn_pkg::fp_op_e fp_op;
  logic        fp_done, acc_nan, out_free;
  logic signed [35:0] ev36, ev10, efold, eclamp;

  assign digit_f = dttn_pkg::digit_to_float(char_q[3:0]);

  always_comb begin
    fp_a  = acc_q;
    fp_b  = dttn_pkg::FLT_TEN;
    fp_op = dttn_pkg::FP_MUL;
    case (cmd_i.sel)
      dttn_pkg::OPS_ACC_TEN: begin
        fp_a = acc_q; fp_b = dttn_pkg::FLT_TEN; fp_op = dttn_pkg::FP_MUL;
      end
      dttn_pkg::OPS_ACC_DIG: begin
        fp_a = acc_q; fp_b = digit_f; fp_op = dttn_pkg::FP_ADD;
      end
      dttn_pkg::OPS_W_DIV: begin
        fp_a = w_q; fp_b = dttn_pkg::FLT_TEN; fp_op = dttn_pkg::FP_DIV10;
      end
      dttn_pkg::OPS_DIG_W: begin
        fp_a = digit_f; fp_b = w_q; fp_op = dttn_pkg::FP_MUL;
      end
      dttn_pkg::OPS_ACC_TMP: begin
        fp_a = acc_q; fp_b = tmp_q; fp_op = dttn_pkg::FP_ADD;
      end
      dttn_pkg::OPS_BASE_SQ: begin
        fp_a = base_q; fp_b = base_q; fp_op = dttn_pkg::FP_MUL;
      end
      dttn_pkg::OPS_ACC_BASE: begin
        fp_a = acc_q; fp_b = base_q; fp_op = dttn_pkg::FP_MUL;
      end
      default: ;
    endcase
  end

  dttn_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.fp_start),
    .op_i    (fp_op),
    .a_i     (fp_a),
    .b_i     (fp_b),
    .done_o  (fp_done),
    .res_o   (fp_res)
  );

  assign ifold  = (acc_q << 3) + (acc_q << 1) + {24'd0, char_i} - 32'd48;
  assign ev36   = {{4{expv_q[31]}}, expv_q};
  assign ev10   = (ev36 <<< 3) + (ev36 <<< 1);
  assign efold  = ev10 + $signed({28'd0, char_i}) - 36'sd48;
  assign eclamp = (efold > dttn_pkg::EXP_MAX) ? dttn_pkg::EXP_MAX
                : (efold < -dttn_pkg::EXP_MAX) ? -dttn_pkg::EXP_MAX : efold;
  assign emag   = expv_q[31] ? (32'd0 - expv_q) : expv_q;

  assign acc_nan = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0);
  assign fin_f   = acc_nan ? dttn_pkg::FLT_QNAN : (acc_q ^ {cmd_i.man_neg, 31'd0});
  assign fin_i   = cmd_i.man_neg ? (32'd0 - acc_q) : acc_q;
  assign out_free = !outv_q || out_ready_i;

  always_comb begin
    acc_d  = acc_q;
    w_d    = w_q;
    tmp_d  = tmp_q;
    base_d = base_q;
    expv_d = expv_q;
    mcnt_d = mcnt_q;
    char_d = char_q;
    sel_d  = sel_q;
    outv_d = outv_q && !out_ready_i;
    outd_d = outd_q;
    outk_d = outk_q;
    if (cmd_i.char_load) char_d = char_i;
    if (cmd_i.int_fold) acc_d = ifold;
    if (cmd_i.exp_fold) expv_d = eclamp[31:0];
    if (cmd_i.fp_start) sel_d = cmd_i.sel;
    if (cmd_i.exp_init) begin
      mcnt_d = emag[30:0];
      base_d = (cmd_i.exp_neg ^ expv_q[31]) ? dttn_pkg::FLT_TENTH : dttn_pkg::FLT_TEN;
    end
    if (cmd_i.mcnt_step) begin
      mcnt_d = mcnt_q[0] ? (mcnt_q - 31'd1) : {1'b0, mcnt_q[30:1]};
    end
    if (fp_done) begin
      case (sel_q)
        dttn_pkg::OPS_W_DIV:   w_d    = fp_res;
        dttn_pkg::OPS_DIG_W:   tmp_d  = fp_res;
        dttn_pkg::OPS_BASE_SQ: base_d = fp_res;
        default:               acc_d  = fp_res;
      endcase
    end
    if (cmd_i.out_load) begin
      outv_d = 1'b1;
      outd_d = cmd_i.kind ? fin_i : fin_f;
      outk_d = cmd_i.kind;
    end
    if (cmd_i.init) begin
      acc_d  = 32'd0;
      w_d    = dttn_pkg::FLT_ONE;
      expv_d = 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 32'd0;
      w_q    <= dttn_pkg::FLT_ONE;
      expv_q <= 32'sd0;
      outv_q <= 1'b0;
      sel_q  <= dttn_pkg::OPS_ACC_TEN;
    end else begin
      acc_q  <= acc_d;
      w_q    <= w_d;
      expv_q <= expv_d;
      outv_q <= outv_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q  <= tmp_d;
    base_q <= base_d;
    mcnt_q <= mcnt_d;
    char_q <= char_d;
    outd_q <= outd_d;
    outk_q <= outk_d;
  end

  assign status_o.fp_done   = fp_done;
  assign status_o.exp_zero  = expv_q == 32'sd0;
  assign status_o.mcnt_one  = mcnt_q == 31'd1;
  assign status_o.mcnt_even = !mcnt_q[0];
  assign status_o.out_free  = out_free;

  assign out_valid_o = outv_q;
  assign out_value_o = outd_q;
  assign out_kind_o  = outk_q;

endmodule

// File: rtl/dttn_ctrl.sv
module dttn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_i,
  input  logic               last_i,
  input  logic               kind_i,
  input  dttn_pkg::status_t  status_i,
  output dttn_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_IFOLD,
    ACT_EFOLD,
    ACT_INT_DIGIT,
    ACT_FRAC_DIGIT
  } act_e;

  dttn_pkg::ctrl_state_e st_d, st_q;
  dttn_pkg::phase_e      ph_d, ph_q, ph_dec;
  logic kind_d, kind_q, neg_d, neg_q, eneg_d, eneg_q, last_d, last_q;
  logic accept, is_dig, is_frac_sep, is_exp, is_sign;
  act_e act;

  assign in_ready_o  = st_q == dttn_pkg::C_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign is_dig      = (char_i >= dttn_pkg::CH_ZERO) && (char_i <= dttn_pkg::CH_NINE);
  assign is_frac_sep = (char_i == dttn_pkg::CH_DOT) || (char_i == dttn_pkg::CH_COMMA);
  assign is_exp      = (char_i == dttn_pkg::CH_LE) || (char_i == dttn_pkg::CH_UE);
  assign is_sign     = (char_i == dttn_pkg::CH_MINUS) || (char_i == dttn_pkg::CH_PLUS);

  // first float character is parsed as an integer-part character
  assign ph_dec = (ph_q == dttn_pkg::PH_FIRST) ? dttn_pkg::PH_INT : ph_q;

  always_comb begin
    st_d   = st_q;
    ph_d   = ph_q;
    kind_d = kind_q;
    neg_d  = neg_q;
    eneg_d = eneg_q;
    last_d = last_q;
    act    = ACT_NONE;
    if (accept) begin
      last_d = last_i;
      if ((ph_q == dttn_pkg::PH_FIRST) && (is_sign || kind_i)) begin
        kind_d = kind_i;
        ph_d   = kind_i ? dttn_pkg::PH_IFOLD : dttn_pkg::PH_INT;
        if (is_sign) neg_d = char_i == dttn_pkg::CH_MINUS;
        else act = ACT_IFOLD;
      end else begin
        if (ph_q == dttn_pkg::PH_FIRST) kind_d = kind_i;
        case (ph_dec)
          dttn_pkg::PH_INT: begin
            if (is_dig) begin
              act  = ACT_INT_DIGIT;
              ph_d = dttn_pkg::PH_INT;
            end else if (is_frac_sep) ph_d = dttn_pkg::PH_FRAC;
            else if (is_exp) ph_d = dttn_pkg::PH_EXP_FIRST;
            else ph_d = dttn_pkg::PH_DONE;
          end
          dttn_pkg::PH_FRAC: begin
            if (is_dig) act = ACT_FRAC_DIGIT;
            else if (is_exp) ph_d = dttn_pkg::PH_EXP_FIRST;
            else ph_d = dttn_pkg::PH_DONE;
          end
          dttn_pkg::PH_EXP_FIRST: begin
            ph_d = dttn_pkg::PH_EXP;
            if (char_i == dttn_pkg::CH_MINUS) eneg_d = 1'b1;
            else if (char_i != dttn_pkg::CH_PLUS) act = ACT_EFOLD;
          end
          dttn_pkg::PH_EXP:   act = ACT_EFOLD;
          dttn_pkg::PH_IFOLD: act = ACT_IFOLD;
          default: ;
        endcase
      end
      case (act)
        ACT_INT_DIGIT:  st_d = dttn_pkg::C_INT_MUL;
        ACT_FRAC_DIGIT: st_d = dttn_pkg::C_FRAC_DIV;
        default:        st_d = last_i ? dttn_pkg::C_FIN : dttn_pkg::C_IDLE;
      endcase
    end
    case (st_q)
      dttn_pkg::C_IDLE: ;
      dttn_pkg::C_INT_MUL:  st_d = dttn_pkg::C_INT_MUL_W;
      dttn_pkg::C_INT_MUL_W: if (status_i.fp_done) st_d = dttn_pkg::C_INT_ADD;
      dttn_pkg::C_INT_ADD:  st_d = dttn_pkg::C_INT_ADD_W;
      dttn_pkg::C_FRAC_DIV: st_d = dttn_pkg::C_FRAC_DIV_W;
      dttn_pkg::C_FRAC_DIV_W: if (status_i.fp_done) st_d = dttn_pkg::C_FRAC_MUL;
      dttn_pkg::C_FRAC_MUL: st_d = dttn_pkg::C_FRAC_MUL_W;
      dttn_pkg::C_FRAC_MUL_W: if (status_i.fp_done) st_d = dttn_pkg::C_FRAC_ADD;
      dttn_pkg::C_FRAC_ADD: st_d = dttn_pkg::C_FRAC_ADD_W;
      dttn_pkg::C_INT_ADD_W, dttn_pkg::C_FRAC_ADD_W: begin
        if (status_i.fp_done) st_d = last_q ? dttn_pkg::C_FIN : dttn_pkg::C_IDLE;
      end
      dttn_pkg::C_FIN: begin
        st_d = (kind_q || status_i.exp_zero) ? dttn_pkg::C_OUT : dttn_pkg::C_EXP_INIT;
      end
      dttn_pkg::C_EXP_INIT: st_d = dttn_pkg::C_EXP_STEP;
      dttn_pkg::C_EXP_STEP: begin
        st_d = status_i.mcnt_one ? dttn_pkg::C_EXP_LAST_W : dttn_pkg::C_EXP_STEP_W;
      end
      dttn_pkg::C_EXP_STEP_W: if (status_i.fp_done) st_d = dttn_pkg::C_EXP_STEP;
      dttn_pkg::C_EXP_LAST_W: if (status_i.fp_done) st_d = dttn_pkg::C_OUT;
      dttn_pkg::C_OUT: begin
        if (status_i.out_free) begin
          st_d   = dttn_pkg::C_IDLE;
          ph_d   = dttn_pkg::PH_FIRST;
          kind_d = 1'b0;
          neg_d  = 1'b0;
          eneg_d = 1'b0;
        end
      end
      default: st_d = dttn_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.sel     = dttn_pkg::OPS_ACC_TEN;
    cmd_o.kind    = kind_q;
    cmd_o.man_neg = neg_q;
    cmd_o.exp_neg = eneg_q;
    case (st_q)
      dttn_pkg::C_IDLE: begin
        cmd_o.char_load = accept;
        cmd_o.int_fold  = act == ACT_IFOLD;
        cmd_o.exp_fold  = act == ACT_EFOLD;
      end
      dttn_pkg::C_INT_MUL: begin
        cmd_o.fp_start = 1'b1;
        cmd_o.sel      = dttn_pkg::OPS_ACC_TEN;
      end
      dttn_pkg::C_INT_ADD: begin
        cmd_o.fp_start = 1'b1;
        cmd_o.sel      = dttn_pkg::OPS_ACC_DIG;
      end
      dttn_pkg::C_FRAC_DIV: begin
        cmd_o.fp_start = 1'b1;
        cmd_o.sel      = dttn_pkg::OPS_W_DIV;
      end
      dttn_pkg::C_FRAC_MUL: begin
        cmd_o.fp_start = 1'b1;
        cmd_o.sel      = dttn_pkg::OPS_DIG_W;
      end
      dttn_pkg::C_FRAC_ADD: begin
        cmd_o.fp_start = 1'b1;
        cmd_o.sel      = dttn_pkg::OPS_ACC_TMP;
      end
      dttn_pkg::C_EXP_INIT: cmd_o.exp_init = 1'b1;
      dttn_pkg::C_EXP_STEP: begin
        cmd_o.fp_start  = 1'b1;
        cmd_o.mcnt_step = !status_i.mcnt_one;
        cmd_o.sel = (status_i.mcnt_one || !status_i.mcnt_even) ? dttn_pkg::OPS_ACC_BASE
                                                                : dttn_pkg::OPS_BASE_SQ;
      end
      dttn_pkg::C_OUT: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.init     = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= dttn_pkg::C_IDLE;
      ph_q   <= dttn_pkg::PH_FIRST;
      kind_q <= 1'b0;
      neg_q  <= 1'b0;
      eneg_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      kind_q <= kind_d;
      neg_q  <= neg_d;
      eneg_q <= eneg_d;
      last_q <= last_d;
    end
  end

endmodule

// File: rtl/decimal_text_to_number.sv
// Parses one text cell, one byte per item, into a 32-bit integer or IEEE
// single value, one item at a time. A sign, integer-mode or exponent byte
// is handled without the floating-point unit. A float integer digit takes
// one multiply and one add on the shared floating-point unit; a fraction
// digit adds a divide by ten through a reciprocal multiply before those.
// For a float with a nonzero exponent, the last byte then applies the
// exponent by square-and-multiply on the same unit, up to about 62
// multiplies. The result waits in an output register.
module decimal_text_to_number (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // char_code
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // value_bits
  output logic        m_axis_tuser_o   // result_kind
);

  dttn_pkg::cmd_t    cmd;
  dttn_pkg::status_t status;

  dttn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .char_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .kind_i     (s_axis_tuser_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dttn_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o)
  );

endmodule

// File: rtl/dttn_checker.sv
module dttn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken right after last item");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared while input was open");

endmodule

bind decimal_text_to_number dttn_checker u_dttn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dttn_pkg::*;

  class cell_scoreboard;
    phase_e      ph;
    bit          kind_q;
    bit          man_neg;
    logic [31:0] acc;
    logic [31:0] weight;
    int          exp_val;
    bit          exp_neg;
    logic [32:0] pending[$];
    int          errors;
    int          checked;
    int          n_float;
    int          n_int;

    function new();
      errors = 0;
      checked = 0;
      n_float = 0;
      n_int = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_FIRST;
      kind_q = 1'b0;
      man_neg = 1'b0;
      acc = '0;
      weight = FLT_ONE;
      exp_val = 0;
      exp_neg = 1'b0;
    endfunction

    function logic [31:0] round_pack(bit s, longint e, logic [127:0] sig);
      int          p;
      longint      ee;
      longint      sh;
      logic [127:0] keep;
      logic [127:0] rem;
      logic [127:0] half;
      logic [127:0] r;
      if (sig == 0) return {s, 31'b0};
      p = 127;
      while (!sig[p]) p--;
      ee = e + p + 127;
      if (ee >= 255) return {s, 8'hFF, 23'b0};
      sh = (ee >= 1) ? p - 23 : -149 - e;
      if (sh > 120) return {s, 31'b0};
      if (sh > 0) begin
        keep = sig >> sh;
        rem = sig & ((128'd1 << sh) - 1);
        half = 128'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0])) keep++;
      end else begin
        keep = sig << (-sh);
      end
      if (ee >= 1) begin
        r = 128'(ee - 1);
        r = (r << 23) + keep;
        return {s, r[30:0]};
      end
      return {s, keep[30:0]};
    endfunction

    function void unpack(logic [31:0] a, output logic [127:0] m, output longint e);
      if (a[30:23] == 0) begin
        m = a[22:0];
        e = -149;
      end else begin
        m = {1'b1, a[22:0]};
        e = longint'(a[30:23]) - 150;
      end
      while (m != 0 && !m[23]) begin
        m = m << 1;
        e--;
      end
    endfunction

    function bit is_nan(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
    endfunction

    function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma;
      logic [127:0] mb;
      longint       ea;
      longint       eb;
      bit           s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return FLT_QNAN;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
        if (a[30:0] == 0 || b[30:0] == 0) return FLT_QNAN;
        return {s, 8'hFF, 23'b0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'b0};
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      return round_pack(s, ea + eb, ma * mb);
    endfunction

    // operands are never negative here
    function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] t;
      longint       ea;
      longint       eb;
      longint       d;
      if (is_nan(a) || is_nan(b)) return FLT_QNAN;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return FLT_INF;
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      if (eb > ea) begin
        t = ma; ma = mb; mb = t;
        d = ea; ea = eb; eb = d;
      end
      d = ea - eb;
      ma = ma << 64;
      mb = mb << 64;
      if (d >= 100) begin
        mb = 128'd1;
      end else begin
        t = mb >> d;
        if ((t << d) != mb) t[0] = 1'b1;
        mb = t;
      end
      return round_pack(1'b0, ea - 64, ma + mb);
    endfunction

    function logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] q;
      longint       ea;
      longint       eb;
      if (a[30:0] == 0) return a;
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      q = (ma << 60) / mb;
      q = (q << 1) | (((ma << 60) % mb) != 0);
      return round_pack(1'b0, ea - eb - 61, q);
    endfunction

    function logic [31:0] digit_value(logic [7:0] c);
      return round_pack(1'b0, 0, 128'(c - CH_ZERO));
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void fold_exponent(logic [7:0] c);
      longint v;
      v = longint'(exp_val) * 10 + (longint'(c) - 48);
      if (v > EXP_MAX) v = EXP_MAX;
      if (v < -EXP_MAX) v = -EXP_MAX;
      exp_val = int'(v);
    endfunction

    function void float_char(logic [7:0] c);
      case (ph)
        PH_INT: begin
          if (is_digit(c)) acc = fadd(fmul(acc, FLT_TEN), digit_value(c));
          else if (c == CH_DOT || c == CH_COMMA) ph = PH_FRAC;
          else if (c == CH_LE || c == CH_UE) ph = PH_EXP_FIRST;
          else ph = PH_DONE;
        end
        PH_FRAC: begin
          if (is_digit(c)) begin
            weight = fdiv(weight, FLT_TEN);
            acc = fadd(acc, fmul(digit_value(c), weight));
          end else if (c == CH_LE || c == CH_UE) begin
            ph = PH_EXP_FIRST;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_EXP_FIRST: begin
          ph = PH_EXP;
          if (c == CH_MINUS) exp_neg = 1'b1;
          else if (c != CH_PLUS) fold_exponent(c);
        end
        PH_EXP: fold_exponent(c);
        default: ;
      endcase
    endfunction

    function logic [31:0] float_value();
      logic [31:0] v;
      logic [31:0] base;
      longint      e;
      longint      m;
      v = acc;
      e = exp_neg ? -longint'(exp_val) : longint'(exp_val);
      if (e != 0) begin
        base = (e < 0) ? FLT_TENTH : FLT_TEN;
        m = (e < 0) ? -e : e;
        while (m != 1) begin
          if (m % 2 == 0) begin
            base = fmul(base, base);
            m = m / 2;
          end else begin
            v = fmul(v, base);
            m--;
          end
        end
        v = fmul(v, base);
      end
      if (is_nan(v)) return FLT_QNAN;
      return v ^ {man_neg, 31'b0};
    endfunction

    function void note_char(logic [7:0] c, bit last, bit kind);
      logic [31:0] r;
      if (ph == PH_FIRST) begin
        kind_q = kind;
        if (c == CH_MINUS || c == CH_PLUS) begin
          man_neg = (c == CH_MINUS);
          ph = kind_q ? PH_IFOLD : PH_INT;
        end else if (kind_q) begin
          ph = PH_IFOLD;
          acc = acc * 10 + (32'(c) - 32'd48);
        end else begin
          ph = PH_INT;
          float_char(c);
        end
      end else if (ph == PH_IFOLD) begin
        acc = acc * 10 + (32'(c) - 32'd48);
      end else begin
        float_char(c);
      end
      if (!last) return;
      if (kind_q) begin
        r = man_neg ? 32'd0 - acc : acc;
        n_int++;
      end else begin
        r = float_value();
        n_float++;
      end
      pending.push_back({kind_q, r});
      clear();
    endfunction

    function void check_result(logic [31:0] bits, logic kind);
      logic [32:0] x;
      if (pending.size() == 0) begin
        $error("unexpected result value_bits=%h result_kind=%0d", bits, kind);
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (bits !== x[31:0]) begin
        $error("value_bits expected %h actual %h", x[31:0], bits);
        errors++;
      end
      if (kind !== x[32]) begin
        $error("result_kind expected %0d actual %0d", x[32], kind);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        s_last;
  logic        s_user;
  logic        m_valid;
  logic        m_ready;
  logic [31:0] m_data;
  logic        m_user;

  cell_scoreboard sb;
  int  tx_idle;
  int  rx_stall;
  bit  hold_req;
  int  sent;

  decimal_text_to_number u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // result side
  initial begin
    m_ready = 1'b0;
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end
      m_ready <= ($urandom_range(99) >= rx_stall);
      @(posedge clk);
      if (m_valid && m_ready) sb.check_result(m_data, m_user);
    end
  end

  task automatic send_char(logic [7:0] c, bit last, bit kind);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle && gap < 200) gap++;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= c;
    s_last <= last;
    s_user <= kind;
    do @(posedge clk); while (!s_ready);
    sb.note_char(c, last, kind);
    sent++;
  endtask

  task automatic send_cell(string txt, bit kind);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1, kind);
  endtask

  function automatic string digits(int n);
    string t;
    t = "";
    for (int i = 0; i < n; i++) t = {t, string'(8'(8'h30 + $urandom_range(9)))};
    return t;
  endfunction

  task automatic random_cell();
    string t;
    bit    kind;
    int    sel;
    t = "";
    kind = $urandom_range(1);
    sel = $urandom_range(99);
    if (sel < 80) begin
      case ($urandom_range(3))
        0: t = "-";
        1: t = "+";
        default: ;
      endcase
      if (kind) begin
        t = {t, digits($urandom_range(1, 11))};
      end else begin
        t = {t, digits($urandom_range(0, 6))};
        if ($urandom_range(1)) begin
          t = {t, string'($urandom_range(1) ? CH_DOT : CH_COMMA), digits($urandom_range(0, 4))};
        end
        if ($urandom_range(2) == 0) begin
          t = {t, string'($urandom_range(1) ? CH_LE : CH_UE)};
          case ($urandom_range(2))
            0: t = {t, "-"};
            1: t = {t, "+"};
            default: ;
          endcase
          t = {t, digits($urandom_range(9) == 0 ? $urandom_range(3, 11) : $urandom_range(0, 2))};
        end
      end
      if (t.len() == 0) t = "0";
    end else begin
      for (int i = $urandom_range(1, 6); i > 0; i--) t = {t, string'(8'($urandom_range(1, 255)))};
      if ($urandom_range(3) == 0) t = {t, string'(8'h00)};
    end
    send_cell(t, kind);
  endtask

  task automatic drain();
    int n;
    n = 0;
    s_valid <= 1'b0;
    while (sb.pending.size() != 0 && n < 2000000) begin
      @(posedge clk);
      n++;
    end
    repeat (8000) @(posedge clk);
  endtask

  initial begin
    sb = new();
    s_valid = 1'b0;
    s_data = '0;
    s_last = 1'b0;
    s_user = 1'b0;
    rst_n = 1'b0;
    tx_idle = 0;
    rx_stall = 0;
    hold_req = 1'b0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cell("0", 1'b1);
    send_cell("2147483647", 1'b1);
    send_cell("-2147483648", 1'b1);
    send_cell("4294967299", 1'b1);
    send_cell("+a", 1'b1);
    send_cell("-", 1'b1);
    send_cell("+", 1'b0);
    send_cell("-", 1'b0);
    send_cell("-3,25", 1'b0);
    send_cell("12.5e1", 1'b0);
    send_cell("7e", 1'b0);
    send_cell("2E-", 1'b0);
    send_cell("1e99", 1'b0);
    send_cell("1e-99", 1'b0);
    send_cell("0e99999999999", 1'b0);
    send_cell("12x3", 1'b0);
    send_cell("1.2.3", 1'b0);
    send_cell("e5", 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(8'h00, 1'b1, 1'b1);
    send_char(8'hFF, 1'b1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin tx_idle = 0;  rx_stall = 0;  hold_req = 1'b1; end
        1: begin tx_idle = 88; rx_stall = 0;  end
        2: begin tx_idle = 0;  rx_stall = 88; end
        default: begin tx_idle = 15; rx_stall = 15; end
      endcase
      while (sent < 21 + (ph + 1) * 260) random_cell();
    end
    drain();

    $display("cells parsed: %0d float, %0d integer; %0d results compared",
             sb.n_float, sb.n_int, sb.checked);
    $display("idle phases: none, sender idle, receiver stall, both; one long output hold");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dttn_pkg.sv
rtl/dttn_fpu.sv
rtl/dttn_datapath.sv
rtl/dttn_ctrl.sv
rtl/decimal_text_to_number.sv
rtl/dttn_checker.sv
tb/tb_top.sv
